/* design/gsra_pkg.sv */
// Package for the grid slot run allocator: field widths, command, status and
// slot codes, controller states and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package gsra_pkg;

    localparam int GRID_SIZE_DEF = 9;
    localparam int MAX_RUN_DEF   = 4;

    localparam int CMD_W  = 3;
    localparam int ROW_W  = 4;
    localparam int COL_W  = 4;
    localparam int CNT_W  = 3;
    localparam int STAT_W = 2;
    localparam int SLOT_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR   = 3'd0,
        CMD_RESERVE = 3'd1,
        CMD_AUTO    = 3'd2,
        CMD_HOLD    = 3'd3,
        CMD_CONFIRM = 3'd4,
        CMD_CANCEL  = 3'd5,
        CMD_READ    = 3'd6
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_NORUN   = 2'd1,
        ST_INVALID = 2'd2,
        ST_TAKEN   = 2'd3
    } status_t;

    typedef enum logic [SLOT_W-1:0] {
        SLOT_FREE     = 2'd0,
        SLOT_HELD     = 2'd1,
        SLOT_RESERVED = 2'd2
    } slot_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ONE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        WR_SINGLE,
        WR_AUTO,
        WR_SWEEP
    } wsel_t;

    // controller -> datapath
    typedef struct packed {
        logic    latch;        // capture input item fields
        logic    rd_coord;     // read row given by the item
        logic    rd_scan0;     // start scan at row 0
        logic    rd_scan_next; // advance scan to the next row
        logic    clear_all;
        logic    wr_en;
        wsel_t   wr_sel;
        logic    res_we;
        status_t res_status;
        logic    res_run;
        logic    res_slot;
        logic    out_load;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             coord_ok;
        logic             cnt_ok;
        logic             cnt_fits;
        logic             slot_free;
        logic             run_found;
        logic             last_row;
    } dp_stat_t;

endpackage

`default_nettype wire

/* design/gsra_ctrl.sv */
// Controller state machine for the grid slot run allocator.
// Depends on gsra_pkg; drives gsra_dp through dp_cmd_t, reads dp_stat_t.
`default_nettype none

module gsra_ctrl
    import gsra_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = cmd.out_load || (out_valid_reg && !out_ready);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                case (stat.op)
                    CMD_RESERVE, CMD_HOLD, CMD_READ:
                        state_next = stat.coord_ok ? S_ONE : S_DONE;
                    CMD_AUTO:
                        state_next = (stat.cnt_ok && stat.cnt_fits) ? S_SCAN : S_DONE;
                    CMD_CONFIRM, CMD_CANCEL:
                        state_next = S_SCAN;
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_ONE:
                state_next = S_DONE;
            S_SCAN:
            begin
                if (stat.last_row || (stat.op == CMD_AUTO && stat.run_found))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        cmd.wr_sel     = WR_SINGLE;
        cmd.res_status = ST_OK;
        case (state_reg)
            S_IDLE:
                cmd.latch = in_valid;
            S_DECODE:
            begin
                case (stat.op)
                    CMD_CLEAR:
                    begin
                        cmd.clear_all = 1'b1;
                        cmd.res_we    = 1'b1;
                    end
                    CMD_RESERVE, CMD_HOLD, CMD_READ:
                    begin
                        if (stat.coord_ok)
                            cmd.rd_coord = 1'b1;
                        else
                        begin
                            cmd.res_we     = 1'b1;
                            cmd.res_status = ST_INVALID;
                        end
                    end
                    CMD_AUTO:
                    begin
                        if (!stat.cnt_ok)
                        begin
                            cmd.res_we     = 1'b1;
                            cmd.res_status = ST_INVALID;
                        end
                        else if (!stat.cnt_fits)
                        begin
                            cmd.res_we     = 1'b1;
                            cmd.res_status = ST_NORUN;
                        end
                        else
                            cmd.rd_scan0 = 1'b1;
                    end
                    CMD_CONFIRM, CMD_CANCEL:
                        cmd.rd_scan0 = 1'b1;
                    default:
                    begin
                        cmd.res_we     = 1'b1;
                        cmd.res_status = ST_INVALID;
                    end
                endcase
            end
            S_ONE:
            begin
                cmd.res_we = 1'b1;
                if (stat.op == CMD_READ)
                    cmd.res_slot = 1'b1;
                else if (stat.slot_free)
                    cmd.wr_en = 1'b1;
                else
                    cmd.res_status = ST_TAKEN;
            end
            S_SCAN:
            begin
                if (stat.op == CMD_AUTO)
                begin
                    if (stat.run_found)
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_sel  = WR_AUTO;
                        cmd.res_we  = 1'b1;
                        cmd.res_run = 1'b1;
                    end
                    else if (stat.last_row)
                    begin
                        cmd.res_we     = 1'b1;
                        cmd.res_status = ST_NORUN;
                    end
                    else
                        cmd.rd_scan_next = 1'b1;
                end
                else
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_SWEEP;
                    if (stat.last_row)
                        cmd.res_we = 1'b1;
                    else
                        cmd.rd_scan_next = 1'b1;
                end
            end
            S_DONE:
                cmd.out_load = out_free;
            default:
            begin
                cmd.latch = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/gsra_dp.sv */
// Datapath for the grid slot run allocator: row-wide slot memory with per-row
// valid bits, run search over one row, row update logic and result registers.
// Depends on gsra_pkg; controlled by gsra_ctrl.
`default_nettype none

module gsra_dp
    import gsra_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF,
    parameter int MAX_RUN   = MAX_RUN_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [CMD_W-1:0]  cmd_in,
    input  wire logic [ROW_W-1:0]  row_in,
    input  wire logic [COL_W-1:0]  col_in,
    input  wire logic [CNT_W-1:0]  count_in,
    input  wire dp_cmd_t           cmd,
    output dp_stat_t               stat,
    output logic [STAT_W-1:0]      status,
    output logic [ROW_W-1:0]       run_row,
    output logic [COL_W-1:0]       run_col,
    output logic [SLOT_W-1:0]      slot_state
);

    localparam int RW   = $clog2(GRID_SIZE);
    localparam int DW   = SLOT_W * GRID_SIZE;
    localparam logic [RW-1:0] LAST_ROW = RW'(GRID_SIZE - 1);

    // item fields
    logic [CMD_W-1:0] op_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [CNT_W-1:0] count_reg;

    // slot memory, one grid row per word
    logic [DW-1:0]        row_mem [GRID_SIZE];
    logic [GRID_SIZE-1:0] row_valid_reg;
    logic [DW-1:0]        rd_data_reg;
    logic                 rd_vld_reg;
    logic [RW-1:0]        scan_row_reg, scan_row_next;

    logic                 rd_en;
    logic [RW-1:0]        rd_addr;
    logic [RW-1:0]        wr_addr;
    logic [DW-1:0]        wr_data;

    logic [DW-1:0]        cur_row;
    logic [RW-1:0]        col_idx;
    logic [SLOT_W-1:0]    cur_slot;
    logic [GRID_SIZE-1:0] free_vec;
    logic [GRID_SIZE-1:0] fits;
    logic [RW-1:0]        found_col;
    logic                 run_found;

    logic [DW-1:0]        single_row, auto_row, sweep_row;
    slot_t                single_val, sweep_val;

    // result staging and output registers
    logic [STAT_W-1:0]    res_status_reg;
    logic [ROW_W-1:0]     res_row_reg;
    logic [COL_W-1:0]     res_col_reg;
    logic [SLOT_W-1:0]    res_slot_reg;
    logic [STAT_W-1:0]    out_status_reg;
    logic [ROW_W-1:0]     out_row_reg;
    logic [COL_W-1:0]     out_col_reg;
    logic [SLOT_W-1:0]    out_slot_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg    <= cmd_in;
            row_reg   <= row_in;
            col_reg   <= col_in;
            count_reg <= count_in;
        end
    end

    assign col_idx = col_reg[RW-1:0];

    // read address and scan counter
    always_comb
    begin
        rd_en         = cmd.rd_coord || cmd.rd_scan0 || cmd.rd_scan_next;
        scan_row_next = scan_row_reg;
        rd_addr       = row_reg[RW-1:0];
        if (cmd.rd_scan0)
        begin
            scan_row_next = '0;
            rd_addr       = '0;
        end
        else if (cmd.rd_scan_next)
        begin
            scan_row_next = scan_row_reg + RW'(1);
            rd_addr       = scan_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_row_reg <= scan_row_next;
        if (rd_en)
        begin
            rd_data_reg <= row_mem[rd_addr];
            rd_vld_reg  <= row_valid_reg[rd_addr];
        end
        if (cmd.wr_en)
            row_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_valid_reg <= '0;
        else if (cmd.clear_all)
            row_valid_reg <= '0;
        else if (cmd.wr_en)
            row_valid_reg[wr_addr] <= 1'b1;
    end

    // a row never written since reset or clear reads as all free
    assign cur_row  = rd_vld_reg ? rd_data_reg : '0;
    assign cur_slot = cur_row[col_idx*SLOT_W +: SLOT_W];

    // run search over the current row
    always_comb
    begin
        for (int j = 0; j < GRID_SIZE; j++)
            free_vec[j] = (cur_row[j*SLOT_W +: SLOT_W] == SLOT_FREE);
        for (int c = 0; c < GRID_SIZE; c++)
        begin
            fits[c] = ((c + int'(count_reg)) <= GRID_SIZE);
            for (int k = 0; k < MAX_RUN; k++)
            begin
                if ((k < int'(count_reg)) && ((c + k) < GRID_SIZE))
                begin
                    if (!free_vec[c + k])
                        fits[c] = 1'b0;
                end
            end
        end
        found_col = '0;
        for (int c = GRID_SIZE - 1; c >= 0; c--)
        begin
            if (fits[c])
                found_col = RW'(c);
        end
        run_found = |fits;
    end

    // row updates
    always_comb
    begin
        single_val = (op_reg == CMD_RESERVE) ? SLOT_RESERVED : SLOT_HELD;
        sweep_val  = (op_reg == CMD_CONFIRM) ? SLOT_RESERVED : SLOT_FREE;
        single_row = cur_row;
        single_row[col_idx*SLOT_W +: SLOT_W] = single_val;
        auto_row   = cur_row;
        sweep_row  = cur_row;
        for (int j = 0; j < GRID_SIZE; j++)
        begin
            if ((j >= int'(found_col)) && (j < (int'(found_col) + int'(count_reg))))
                auto_row[j*SLOT_W +: SLOT_W] = SLOT_HELD;
            if (cur_row[j*SLOT_W +: SLOT_W] == SLOT_HELD)
                sweep_row[j*SLOT_W +: SLOT_W] = sweep_val;
        end
    end

    always_comb
    begin
        case (cmd.wr_sel)
            WR_SINGLE:
            begin
                wr_addr = row_reg[RW-1:0];
                wr_data = single_row;
            end
            WR_AUTO:
            begin
                wr_addr = scan_row_reg;
                wr_data = auto_row;
            end
            WR_SWEEP:
            begin
                wr_addr = scan_row_reg;
                wr_data = sweep_row;
            end
            default:
            begin
                wr_addr = scan_row_reg;
                wr_data = cur_row;
            end
        endcase
    end

    // status to the controller
    always_comb
    begin
        stat.op        = op_reg;
        stat.coord_ok  = (int'(row_reg) < GRID_SIZE) && (int'(col_reg) < GRID_SIZE);
        stat.cnt_ok    = (count_reg != '0) && (int'(count_reg) <= MAX_RUN);
        stat.cnt_fits  = (int'(count_reg) <= GRID_SIZE);
        stat.slot_free = (cur_slot == SLOT_FREE);
        stat.run_found = run_found;
        stat.last_row  = (scan_row_reg == LAST_ROW);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_we)
        begin
            res_status_reg <= cmd.res_status;
            res_row_reg    <= cmd.res_run ? ROW_W'(scan_row_reg) : '0;
            res_col_reg    <= cmd.res_run ? COL_W'(found_col) : '0;
            res_slot_reg   <= cmd.res_slot ? cur_slot : '0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_row_reg    <= res_row_reg;
            out_col_reg    <= res_col_reg;
            out_slot_reg   <= res_slot_reg;
        end
    end

    assign status     = out_status_reg;
    assign run_row    = out_row_reg;
    assign run_col    = out_col_reg;
    assign slot_state = out_slot_reg;

endmodule

`default_nettype wire

/* design/grid_seat_run_allocator.sv */
// Grid slot run allocator, top level.
// Depends on gsra_pkg, gsra_ctrl and gsra_dp.
//
// Usage: one command item (cmd, row, col, count) enters on the in_valid /
// in_ready channel; exactly one result item (status, run_row, run_col,
// slot_state) leaves on the out_valid / out_ready channel for each.
// The grid is held one row per memory word; every row-wide job reads a row
// each cycle through a single read port.
// Work per item, from acceptance to result valid:
//   clear, bad arguments, unused command: result written directly
//   reserve, hold, read:                  one row read, then the result
//   confirm, cancel:                      every row swept in turn
//   auto run:                             rows scanned from row 0 until a run
//                                         is found or the last row is done
// One item is worked on at a time; the next is taken once the result has
// been moved to the output register, even while that result waits.
// Reset empties the grid at once through per-row valid bits, so no clearing
// pass is needed. While the receiver stalls, the finished result holds on
// the output and a following item completes its work but waits for the
// output register before returning to accept more.
`default_nettype none

module grid_seat_run_allocator
    import gsra_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF,
    parameter int MAX_RUN   = MAX_RUN_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [CMD_W-1:0]  cmd,
    input  wire logic [ROW_W-1:0]  row,
    input  wire logic [COL_W-1:0]  col,
    input  wire logic [CNT_W-1:0]  count,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [STAT_W-1:0]      status,
    output logic [ROW_W-1:0]       run_row,
    output logic [COL_W-1:0]       run_col,
    output logic [SLOT_W-1:0]      slot_state
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    gsra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    gsra_dp #(
        .GRID_SIZE (GRID_SIZE),
        .MAX_RUN   (MAX_RUN)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_in     (cmd),
        .row_in     (row),
        .col_in     (col),
        .count_in   (count),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .status     (status),
        .run_row    (run_row),
        .run_col    (run_col),
        .slot_state (slot_state)
    );

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for grid_seat_run_allocator: a queue-fed driver, a
// result monitor and an in-bench predictor of the seat grid.
// Depends on gsra_pkg and the grid_seat_run_allocator RTL.

module tb;
    import gsra_pkg::*;

    localparam int GRID        = GRID_SIZE_DEF;
    localparam int MAX_LEN     = MAX_RUN_DEF;
    localparam int TARGET      = 1750;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 250;
    localparam int QUIET_LO    = 700;
    localparam int QUIET_HI    = 1000;
    localparam int DRAIN       = 20;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    typedef struct {
        logic [CMD_W-1:0] op;
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        logic [CNT_W-1:0] n;
    } cmd_item_t;

    typedef struct {
        status_t          st;
        logic [ROW_W-1:0] rr;
        logic [COL_W-1:0] rc;
        slot_t            ss;
    } outcome_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [CMD_W-1:0]  cmd = '0;
    logic [ROW_W-1:0]  row = '0;
    logic [COL_W-1:0]  col = '0;
    logic [CNT_W-1:0]  count = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [STAT_W-1:0] status;
    logic [ROW_W-1:0]  run_row;
    logic [COL_W-1:0]  run_col;
    logic [SLOT_W-1:0] slot_state;

    slot_t     seat_map [GRID*GRID];
    cmd_item_t cmd_q [$];
    outcome_t  outcome_q [$];
    cmd_item_t next_item;
    outcome_t  got;
    outcome_t  want;
    int        sent_count = 0;
    int        result_count = 0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;
    int        idle_cycles = 0;
    int        errors = 0;

    grid_seat_run_allocator u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .row        (row),
        .col        (col),
        .count      (count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .run_row    (run_row),
        .run_col    (run_col),
        .slot_state (slot_state)
    );

    always #6 clk = ~clk;

    // Works out the result of one command and updates the grid copy.
    function automatic outcome_t predict_outcome(logic [CMD_W-1:0] op, logic [ROW_W-1:0] r,
                                                 logic [COL_W-1:0] c, logic [CNT_W-1:0] n);
        outcome_t o;
        bit       found;
        bit       fits;
        int       idx;
        o.st  = ST_OK;
        o.rr  = '0;
        o.rc  = '0;
        o.ss  = SLOT_FREE;
        found = 1'b0;
        idx   = int'(r) * GRID + int'(c);
        case (op)
            CMD_CLEAR:
                foreach (seat_map[i]) seat_map[i] = SLOT_FREE;
            CMD_RESERVE, CMD_HOLD:
                if (r >= GRID || c >= GRID)
                    o.st = ST_INVALID;
                else if (seat_map[idx] != SLOT_FREE)
                    o.st = ST_TAKEN;
                else
                    seat_map[idx] = (op == CMD_RESERVE) ? SLOT_RESERVED : SLOT_HELD;
            CMD_AUTO:
                if (n == 0 || n > MAX_LEN)
                    o.st = ST_INVALID;
                else
                begin
                    o.st = ST_NORUN;
                    for (int rw = 0; rw < GRID && !found; rw++)
                    begin
                        for (int cl = 0; cl + int'(n) <= GRID && !found; cl++)
                        begin
                            fits = 1'b1;
                            for (int k = 0; k < int'(n); k++)
                                if (seat_map[rw*GRID + cl + k] != SLOT_FREE)
                                    fits = 1'b0;
                            if (fits)
                            begin
                                for (int k = 0; k < int'(n); k++)
                                    seat_map[rw*GRID + cl + k] = SLOT_HELD;
                                found = 1'b1;
                                o.st  = ST_OK;
                                o.rr  = rw[ROW_W-1:0];
                                o.rc  = cl[COL_W-1:0];
                            end
                        end
                    end
                end
            CMD_CONFIRM:
                foreach (seat_map[i])
                    if (seat_map[i] == SLOT_HELD)
                        seat_map[i] = SLOT_RESERVED;
            CMD_CANCEL:
                foreach (seat_map[i])
                    if (seat_map[i] == SLOT_HELD)
                        seat_map[i] = SLOT_FREE;
            CMD_READ:
                if (r >= GRID || c >= GRID)
                    o.st = ST_INVALID;
                else
                    o.ss = seat_map[idx];
            default:
                o.st = ST_INVALID;
        endcase
        return o;
    endfunction

    task automatic queue_cmd(logic [CMD_W-1:0] op, logic [ROW_W-1:0] r,
                             logic [COL_W-1:0] c, logic [CNT_W-1:0] n);
        cmd_item_t it;
        it.op = op;
        it.r  = r;
        it.c  = c;
        it.n  = n;
        cmd_q.push_back(it);
    endtask

    task automatic queue_noise();
        queue_cmd(CMD_W'($urandom_range(0, 7)), ROW_W'($urandom_range(0, 15)),
                  COL_W'($urandom_range(0, 15)), CNT_W'($urandom_range(0, 7)));
    endtask

    task automatic report_mismatch(string what);
        errors++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // Sender: a new item is offered only once the last one has gone.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                outcome_q.push_back(predict_outcome(cmd, row, col, count));
                sent_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (cmd_q.size() != 0 &&
                    ((sent_count >= QUIET_LO && sent_count < QUIET_HI) ||
                     $urandom_range(0, 99) >= 25))
                begin
                    next_item = cmd_q.pop_front();
                    in_valid <= 1'b1;
                    cmd      <= next_item.op;
                    row      <= next_item.r;
                    col      <= next_item.c;
                    count    <= next_item.n;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result and throttles out_ready, with one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                result_count++;
                got.st = status_t'(status);
                got.rr = run_row;
                got.rc = run_col;
                got.ss = slot_t'(slot_state);
                if (outcome_q.size() == 0)
                    report_mismatch($sformatf("unexpected result status=%0d", status));
                else
                begin
                    want = outcome_q.pop_front();
                    if (got.st !== want.st || got.rr !== want.rr ||
                        got.rc !== want.rc || got.ss !== want.ss)
                        report_mismatch($sformatf(
                            "result %0d: got st=%0d row=%0d col=%0d slot=%0d, exp %0d/%0d/%0d/%0d",
                            result_count, status, run_row, run_col, slot_state,
                            want.st, want.rr, want.rc, want.ss));
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && result_count >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (result_count >= QUIET_LO && result_count < QUIET_HI)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 25);
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("grid_seat_run_allocator regression: fail");
            $finish;
        end
    end

    initial
    begin
        int pick;
        int len;

        // grid copy starts empty, as the block does after reset
        foreach (seat_map[i]) seat_map[i] = SLOT_FREE;

        // directed: field extremes, every command, the invalid and taken paths
        queue_cmd(CMD_READ,    4'd0,  4'd0,  3'd0);
        queue_cmd(CMD_RESERVE, 4'd0,  4'd0,  3'd7);
        queue_cmd(CMD_RESERVE, 4'd0,  4'd0,  3'd0);   // taken
        queue_cmd(CMD_HOLD,    4'd8,  4'd8,  3'd0);
        queue_cmd(CMD_HOLD,    4'd8,  4'd8,  3'd0);   // taken
        queue_cmd(CMD_READ,    4'd8,  4'd8,  3'd0);
        queue_cmd(CMD_RESERVE, 4'd9,  4'd0,  3'd0);   // bad row
        queue_cmd(CMD_HOLD,    4'd0,  4'd15, 3'd0);   // bad col
        queue_cmd(CMD_READ,    4'd15, 4'd15, 3'd0);
        queue_cmd(CMD_AUTO,    4'd15, 4'd15, 3'd0);   // bad count
        queue_cmd(CMD_AUTO,    4'd0,  4'd0,  3'd5);
        queue_cmd(CMD_AUTO,    4'd0,  4'd0,  3'd7);
        queue_cmd(CMD_AUTO,    4'd0,  4'd0,  3'd4);
        queue_cmd(CMD_AUTO,    4'd0,  4'd0,  3'd1);
        queue_cmd(CMD_CONFIRM, 4'd0,  4'd0,  3'd0);
        queue_cmd(CMD_READ,    4'd0,  4'd1,  3'd0);
        queue_cmd(CMD_CANCEL,  4'd0,  4'd0,  3'd0);   // nothing held
        queue_cmd(CMD_HOLD,    4'd3,  4'd3,  3'd0);
        queue_cmd(CMD_CANCEL,  4'd0,  4'd0,  3'd0);
        queue_cmd(CMD_READ,    4'd3,  4'd3,  3'd0);
        queue_cmd(CMD_UNUSED,  4'd15, 4'd15, 3'd7);
        queue_cmd(CMD_CLEAR,   4'd15, 4'd15, 3'd7);
        queue_cmd(CMD_READ,    4'd0,  4'd0,  3'd0);

        // random: mostly fill-up sessions so the grid runs out of space
        while (cmd_q.size() < TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                if ($urandom_range(0, 99) < 80)
                    queue_cmd(CMD_CLEAR, ROW_W'($urandom_range(0, 15)),
                              COL_W'($urandom_range(0, 15)), CNT_W'($urandom_range(0, 7)));
                len = $urandom_range(30, 70);
                repeat (len)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 55)
                        queue_cmd(CMD_AUTO, ROW_W'($urandom_range(0, 15)),
                                  COL_W'($urandom_range(0, 15)),
                                  CNT_W'($urandom_range(1, MAX_LEN)));
                    else if (pick < 65)
                        queue_cmd(CMD_HOLD, ROW_W'($urandom_range(0, GRID-1)),
                                  COL_W'($urandom_range(0, GRID-1)),
                                  CNT_W'($urandom_range(0, 7)));
                    else if (pick < 75)
                        queue_cmd(CMD_RESERVE, ROW_W'($urandom_range(0, GRID-1)),
                                  COL_W'($urandom_range(0, GRID-1)),
                                  CNT_W'($urandom_range(0, 7)));
                    else if (pick < 88)
                        queue_cmd(CMD_READ, ROW_W'($urandom_range(0, GRID-1)),
                                  COL_W'($urandom_range(0, GRID-1)),
                                  CNT_W'($urandom_range(0, 7)));
                    else if (pick < 93)
                        queue_cmd(CMD_CONFIRM, ROW_W'($urandom_range(0, 15)),
                                  COL_W'($urandom_range(0, 15)),
                                  CNT_W'($urandom_range(0, 7)));
                    else if (pick < 97)
                        queue_cmd(CMD_CANCEL, ROW_W'($urandom_range(0, 15)),
                                  COL_W'($urandom_range(0, 15)),
                                  CNT_W'($urandom_range(0, 7)));
                    else
                        queue_noise();
                end
            end
            else
                repeat ($urandom_range(5, 15)) queue_noise();
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // sample away from the active edge so the queues are settled
        while (cmd_q.size() != 0 || in_valid || outcome_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(posedge clk);

        if (errors == 0)
            $display("grid_seat_run_allocator regression: pass");
        else
            $display("grid_seat_run_allocator regression: fail");
        $finish;
    end

endmodule

/* grid_seat_run_allocator.f */
design/gsra_pkg.sv
design/gsra_ctrl.sv
design/gsra_dp.sv
design/grid_seat_run_allocator.sv
tb/tb.sv
